// ----- rtl/mssc_pkg.sv -----
// Shared types and constants for the TCP SYN MSS clamp.
// Used by mssc_parser, mssc_out_buf and tcp_syn_mss_clamp; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mssc_pkg;

  // Reset value of the MSS limit register.
  localparam logic [15:0] MSS_LIMIT_RST = 16'd1400;

  // Header layout and option kinds.
  localparam logic [5:0] POS_DATA_OFF  = 6'd12;
  localparam logic [5:0] POS_FLAGS     = 6'd13;
  localparam logic [5:0] HDR_MIN_LEN   = 6'd20;
  localparam logic [5:0] POS_MAX       = 6'd63;
  localparam logic [7:0] OPT_EOL       = 8'd0;
  localparam logic [7:0] OPT_NOP       = 8'd1;
  localparam logic [7:0] OPT_MSS       = 8'd2;
  localparam logic [7:0] OPT_MIN_LEN   = 8'd2;
  localparam logic [7:0] OPT_MSS_LEN   = 8'd4;

  // Result buffer geometry.
  localparam int BUF_DEPTH  = 4;
  localparam int BUF_AW     = $clog2(BUF_DEPTH);
  localparam int BUF_CW     = $clog2(BUF_DEPTH + 1);
  // The parser may push two items, so it needs this much headroom.
  localparam logic [BUF_CW-1:0] BUF_ROOM_MAX = BUF_CW'(BUF_DEPTH - 2);

  // Option walk phases.
  typedef enum logic [2:0] {
    PH_KIND   = 3'd0,
    PH_LEN    = 3'd1,
    PH_MSS_HI = 3'd2,
    PH_MSS_LO = 3'd3,
    PH_SKIP   = 3'd4,
    PH_DONE   = 3'd5
  } mssc_phase_t;

  // Input item.
  typedef struct packed {
    logic [7:0] seg_byte;
    logic       seg_last;
  } mssc_in_t;

  // Result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       mss_clamped;
  } mssc_out_t;

  // Up to two result items from one input item.
  typedef struct packed {
    logic [1:0]           cnt;
    mssc_out_t [1:0]      item;
  } mssc_push_t;

  // Result buffer status seen by the parser and the top level.
  typedef struct packed {
    logic [BUF_CW-1:0] count;
    logic              room;
  } mssc_buf_stat_t;

endpackage

`default_nettype wire

// ----- rtl/mssc_parser.sv -----
// Input register and single-pass header/option parser for the MSS clamp.
// Depends on mssc_pkg; pushes results into mssc_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module mssc_parser
  import mssc_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire mssc_in_t       in_data,
  input  wire logic [15:0]    mss_limit,
  input  wire mssc_buf_stat_t buf_stat,
  output mssc_push_t          push
);

  logic        s_valid_r;
  mssc_in_t    s_item_r;
  logic        advance;

  logic [5:0]  pos_r,      pos_nxt;
  logic [5:0]  hlen_r,     hlen_nxt;
  logic        syn_r,      syn_nxt;
  mssc_phase_t phase_r,    phase_nxt;
  logic [7:0]  kind_r,     kind_nxt;
  logic [5:0]  rem_r,      rem_nxt;
  logic [7:0]  held_r,     held_nxt;
  logic        holding_r,  holding_nxt;
  logic        clamp_r,    clamp_nxt;

  // The staged item moves on only when the buffer can take two results.
  assign advance  = s_valid_r && buf_stat.room;
  assign in_stall = s_valid_r && !buf_stat.room;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_item_r <= in_data;
    end
  end

  // Parse one byte against the segment state.
  always_comb begin
    logic [7:0]  b;
    logic        last;
    logic        walk;
    logic [8:0]  opt_end;
    logic [5:0]  rem_calc;
    logic [15:0] mss_val;
    logic [1:0]  cnt;
    logic [7:0]  e0;
    logic [7:0]  e1;

    b        = s_item_r.seg_byte;
    last     = s_item_r.seg_last;
    cnt      = 2'd1;
    e0       = b;
    e1       = 8'd0;
    opt_end  = 9'({3'b000, pos_r} - 9'd1 + {1'b0, b});
    rem_calc = b[5:0] - 6'd2;
    mss_val  = {held_r, b};

    hlen_nxt    = (pos_r == POS_DATA_OFF) ? {b[7:4], 2'b00} : hlen_r;
    syn_nxt     = (pos_r == POS_FLAGS) ? b[1] : syn_r;
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    rem_nxt     = rem_r;
    held_nxt    = held_r;
    holding_nxt = holding_r;
    clamp_nxt   = clamp_r;

    walk = syn_nxt && (hlen_nxt > HDR_MIN_LEN) && (pos_r >= HDR_MIN_LEN) &&
           (pos_r < hlen_nxt);

    if (walk) begin
      unique case (phase_r)
        PH_KIND: begin
          if (b == OPT_EOL) begin
            phase_nxt = PH_DONE;
          end else if (b != OPT_NOP) begin
            kind_nxt  = b;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b < OPT_MIN_LEN || opt_end > {3'b000, hlen_nxt} ||
              (kind_r == OPT_MSS && b != OPT_MSS_LEN)) begin
            phase_nxt = PH_DONE;
          end else begin
            rem_nxt = rem_calc;
            if (rem_calc == 6'd0) begin
              phase_nxt = PH_KIND;
            end else if (kind_r == OPT_MSS) begin
              phase_nxt = PH_MSS_HI;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_MSS_HI: begin
          // Hold the high byte back until the low byte arrives.
          if (!last) begin
            held_nxt    = b;
            holding_nxt = 1'b1;
            phase_nxt   = PH_MSS_LO;
            cnt         = 2'd0;
          end
        end
        PH_MSS_LO: begin
          if (mss_val > mss_limit) begin
            mss_val   = mss_limit;
            clamp_nxt = 1'b1;
          end
          e0          = mss_val[15:8];
          e1          = mss_val[7:0];
          cnt         = 2'd2;
          holding_nxt = 1'b0;
          phase_nxt   = PH_KIND;
        end
        PH_SKIP: begin
          rem_nxt = rem_r - 6'd1;
          if (rem_nxt == 6'd0) begin
            phase_nxt = PH_KIND;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    // Build the result items; the final one carries the clamp flag.
    push.cnt                   = advance ? cnt : 2'd0;
    push.item[0].out_byte      = e0;
    push.item[0].out_last      = last && (cnt == 2'd1);
    push.item[0].mss_clamped   = last && (cnt == 2'd1) && clamp_nxt;
    push.item[1].out_byte      = e1;
    push.item[1].out_last      = last;
    push.item[1].mss_clamped   = last && clamp_nxt;

    // A final byte returns the segment state to reset.
    if (last) begin
      pos_nxt     = 6'd0;
      hlen_nxt    = 6'd0;
      syn_nxt     = 1'b0;
      phase_nxt   = PH_KIND;
      kind_nxt    = 8'd0;
      rem_nxt     = 6'd0;
      held_nxt    = 8'd0;
      holding_nxt = 1'b0;
      clamp_nxt   = 1'b0;
    end else begin
      pos_nxt = (pos_r < POS_MAX) ? pos_r + 6'd1 : POS_MAX;
    end
  end

  // Segment state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 6'd0;
      hlen_r    <= 6'd0;
      syn_r     <= 1'b0;
      phase_r   <= PH_KIND;
      kind_r    <= 8'd0;
      rem_r     <= 6'd0;
      held_r    <= 8'd0;
      holding_r <= 1'b0;
      clamp_r   <= 1'b0;
    end else if (advance) begin
      pos_r     <= pos_nxt;
      hlen_r    <= hlen_nxt;
      syn_r     <= syn_nxt;
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      rem_r     <= rem_nxt;
      held_r    <= held_nxt;
      holding_r <= holding_nxt;
      clamp_r   <= clamp_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mssc_out_buf.sv -----
// Small result buffer: takes up to two items a cycle, gives one a cycle unless out_stall.
// Depends on mssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mssc_out_buf
  import mssc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire mssc_push_t push,
  output mssc_buf_stat_t  stat,
  output logic            out_valid,
  input  wire logic       out_stall,
  output mssc_out_t       out_data
);

  mssc_out_t           buf_r [BUF_DEPTH];
  logic [BUF_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [BUF_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [BUF_CW-1:0]   count_r,  count_nxt;
  logic                pop;
  logic [BUF_AW-1:0]   wr_ptr_p1;

  assign out_valid  = (count_r != '0);
  assign out_data   = buf_r[rd_ptr_r];
  assign pop        = out_valid && !out_stall;
  assign stat.count = count_r;
  assign stat.room  = (count_r <= BUF_ROOM_MAX);
  assign wr_ptr_p1  = wr_ptr_r + BUF_AW'(1);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + BUF_AW'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + BUF_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + BUF_CW'(push.cnt) - BUF_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry writes; a second item lands in the following slot.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      buf_r[wr_ptr_r] <= push.item[0];
    end
    if (push.cnt == 2'd2) begin
      buf_r[wr_ptr_p1] <= push.item[1];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tcp_syn_mss_clamp.sv -----
// TCP SYN MSS clamp: one segment byte in per cycle unless stalled, rewritten bytes out.
// An accepted input item is held in the input register, then in the result buffer;
// either can stall. The held MSS high byte leaves with its low byte, and from then on the
// buffer carries one extra item, so later items wait behind it until an input gap drains it.
// Throughput: one input item per cycle unless stalled; the MSS value gives two results,
// but its held high byte gives none, so the four-entry result buffer keeps pace.
// Reset (rst_n low, synchronous) empties the pipeline, clears segment state
// and sets the MSS limit to 1400.
`timescale 1ns / 1ps
`default_nettype none

module tcp_syn_mss_clamp
  import mssc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire mssc_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output mssc_out_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic [15:0]    mss_limit_r;
  mssc_push_t     push;
  mssc_buf_stat_t buf_stat;

  // Configuration register; write it only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mss_limit_r <= MSS_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      mss_limit_r <= cfg_data;
    end
  end

  // Parser stage.
  mssc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .mss_limit (mss_limit_r),
    .buf_stat  (buf_stat),
    .push      (push)
  );

  // Result buffer.
  mssc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .stat      (buf_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // The buffer never overfills.
  assert property (@(posedge clk) disable iff (!rst_n)
    buf_stat.count <= BUF_CW'(BUF_DEPTH))
    else $error("result buffer overflow");

  // The parser pushes only when the buffer has room for two items.
  assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> buf_stat.room)
    else $error("push without buffer room");

  // One input item never yields three results.
  assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd3)
    else $error("illegal push count");

  // Taking the only buffered item with nothing pushed empties the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && buf_stat.count == BUF_CW'(1) && push.cnt == 2'd0)
      |=> !out_valid)
    else $error("output valid after last item taken");
`endif

endmodule

`default_nettype wire
